// ===== src/imh_pkg.sv =====
// shared types and constants of the indexed min-heap
// no dependencies
`timescale 1ns / 1ps
package imh_pkg;
    localparam int CAPACITY     = 64;
    localparam int HANDLE_COUNT = 128;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int HW = 7;
    localparam int CW = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DEL_MIN = 2'd1,
        REQ_DEL_HANDLE = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FULL = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_IN_USE = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        content;
        logic [HW-1:0]      handle;
    } t_entry;
endpackage

// ===== src/indexed_min_heap.sv =====
// indexed binary min-heap: top level with slot and handle-position memories
// depends on imh_pkg
`timescale 1ns / 1ps
// One request at a time. Slots live in one synchronous memory and handle positions
// in a second one. Each memory has one read port and one write port, and every read
// is registered. The sift moves a hole rather than swapping: each level writes the
// displaced entry once, and the moving entry is written at its final slot. A request
// that is rejected, or whose code is unused, goes from S_DISPATCH straight to S_DONE.
// An insert walks up from the new last slot. A delete-minimum walks down from the
// root. A delete-by-handle lifts the entry to the root and then sinks the last entry.
// The heap has up to seven levels at 64 entries. The result sits in its own output
// register. i_stall holds that register, and a finished request waits in S_DONE while
// the register is full, so the next request can be accepted while a result waits. The
// request side is ready (o_stall low) whenever the block is idle.
module indexed_min_heap (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_req_type,
    input  logic signed [31:0]         i_key,
    input  logic [31:0]                i_content,
    input  logic [6:0]                 i_handle,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [2:0]                 o_status,
    output logic signed [31:0]         o_out_key,
    output logic [31:0]                o_out_content,
    output logic [6:0]                 o_out_handle,
    output logic [6:0]                 o_entry_count
);
    import imh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_POS_RD, S_ENT_GET, S_UP_RD, S_UP_CMP, S_ROOT,
        S_LAST_RD, S_LAST_GET, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_PLACE, S_DONE
    } t_state;

    t_entry slot_mem [1:CAPACITY];
    logic [PW-1:0] pos_mem [0:HANDLE_COUNT-1];
    logic [HANDLE_COUNT-1:0] r_hvalid;

    t_state r_state;
    t_req r_req;
    t_status r_status;
    t_entry r_in, r_cur, r_left, r_rd;
    logic [PW-1:0] r_pos, r_cnt;
    logic [PW-1:0] r_pos_rd;
    logic r_forced;
    logic signed [31:0] r_out_key;
    logic [31:0] r_out_content;
    logic [HW-1:0] r_out_handle;
    logic [PW-1:0] pa;

    logic [PW-1:0]   s_ra;
    logic            s_we;
    logic [PW-1:0]   s_wa;
    t_entry          s_wd;
    logic            p_we;
    logic [HW-1:0]   p_wa;
    logic [PW-1:0]   p_wd;
    logic [PW:0]     s_lc;
    logic [PW:0]     s_rc;
    logic            s_right;
    t_entry          s_child;
    logic [PW-1:0]   s_cidx;
    logic            s_up_move;
    logic            s_dn_move;

    always_ff @(posedge i_clk) begin
        r_rd <= slot_mem[s_ra];
        r_pos_rd <= pos_mem[r_in.handle];
        if (s_we) slot_mem[s_wa] <= s_wd;
        if (p_we) pos_mem[p_wa] <= p_wd;
    end

    assign pa = r_pos >> 1;
    assign o_stall = (r_state != S_IDLE);

    assign s_lc = {r_pos, 1'b0};
    assign s_rc = {r_pos, 1'b1};
    assign s_right = (s_rc <= {1'b0, r_cnt}) && (r_rd.key < r_left.key);
    assign s_child = s_right ? r_rd : r_left;
    assign s_cidx = s_right ? s_rc[PW-1:0] : s_lc[PW-1:0];
    assign s_up_move = r_forced || (r_cur.key < r_rd.key);
    assign s_dn_move = s_child.key < r_cur.key;

    // one slot read, at most one slot write and at most one position write per cycle
    always_comb begin
        s_ra = PW'(1);
        s_we = 1'b0; s_wa = r_pos; s_wd = r_cur;
        p_we = 1'b0; p_wa = r_cur.handle; p_wd = r_pos;
        unique case (r_state)
            S_POS_RD: s_ra = r_pos_rd;
            S_UP_RD: s_ra = pa;
            S_UP_CMP: begin
                if (s_up_move) begin
                    s_we = 1'b1; s_wd = r_rd;
                    p_we = 1'b1; p_wa = r_rd.handle;
                end
            end
            S_LAST_RD: s_ra = r_cnt;
            S_DN_RDL: s_ra = s_lc[PW-1:0];
            S_DN_RDR: s_ra = s_rc[PW-1:0];
            S_DN_CMP: begin
                if (s_dn_move) begin
                    s_we = 1'b1; s_wd = s_child;
                    p_we = 1'b1; p_wa = s_child.handle;
                end
            end
            S_PLACE: begin
                s_we = 1'b1;
                p_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hvalid <= '0;
            r_cnt <= '0;
            o_valid <= 1'b0;
            o_status <= '0;
            o_out_key <= '0;
            o_out_content <= '0;
            o_out_handle <= '0;
            o_entry_count <= '0;
        end else begin
            if (r_state == S_DONE && (!o_valid || !i_stall)) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= t_req'(i_req_type);
                        r_in <= '{key: i_key, content: i_content, handle: i_handle};
                        r_status <= ST_OK;
                        r_out_key <= '0;
                        r_out_content <= '0;
                        r_out_handle <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (r_req)
                        REQ_INSERT: begin
                            if (r_cnt >= PW'(CAPACITY)) begin
                                r_status <= ST_FULL; r_state <= S_DONE;
                            end else if (r_hvalid[r_in.handle]) begin
                                r_status <= ST_IN_USE; r_state <= S_DONE;
                            end else begin
                                r_hvalid[r_in.handle] <= 1'b1;
                                r_cnt <= r_cnt + 1'b1;
                                r_pos <= r_cnt + 1'b1;
                                r_cur <= r_in;
                                r_forced <= 1'b0;
                                r_state <= S_UP_RD;
                            end
                        end
                        REQ_DEL_MIN: begin
                            if (r_cnt == '0) begin
                                r_status <= ST_EMPTY; r_state <= S_DONE;
                            end else begin
                                r_state <= S_ROOT;
                            end
                        end
                        REQ_DEL_HANDLE: begin
                            if (r_cnt == '0) begin
                                r_status <= ST_EMPTY; r_state <= S_DONE;
                            end else if (!r_hvalid[r_in.handle]) begin
                                r_status <= ST_UNKNOWN; r_state <= S_DONE;
                            end else begin
                                r_state <= S_POS_RD;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_POS_RD: begin
                    r_pos <= r_pos_rd;
                    r_state <= S_ENT_GET;
                end
                S_ENT_GET: begin
                    r_cur <= r_rd;
                    r_forced <= 1'b1;
                    r_state <= S_UP_RD;
                end
                S_UP_RD: begin
                    if (r_pos == PW'(1)) r_state <= r_forced ? S_LAST_RD : S_PLACE;
                    else r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (s_up_move) begin
                        r_pos <= pa;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_ROOT: begin
                    r_cur <= r_rd;
                    r_state <= S_LAST_RD;
                end
                S_LAST_RD: begin
                    // r_cur is the entry leaving the heap
                    if (r_req == REQ_DEL_MIN) r_out_key <= r_cur.key;
                    r_out_content <= r_cur.content;
                    r_out_handle <= r_cur.handle;
                    r_hvalid[r_cur.handle] <= 1'b0;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == PW'(1)) r_state <= S_DONE;
                    else r_state <= S_LAST_GET;
                end
                S_LAST_GET: begin
                    r_cur <= r_rd;
                    r_pos <= PW'(1);
                    r_state <= S_DN_RDL;
                end
                S_DN_RDL: begin
                    if (s_lc > {1'b0, r_cnt}) r_state <= S_PLACE;
                    else r_state <= S_DN_RDR;
                end
                S_DN_RDR: begin
                    r_left <= r_rd;
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (s_dn_move) begin
                        r_pos <= s_cidx;
                        r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        o_status <= r_status;
                        o_out_key <= r_out_key;
                        o_out_content <= r_out_content;
                        o_out_handle <= r_out_handle;
                        o_entry_count <= r_cnt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= PW'(CAPACITY))) else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_content))
        else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= 3'd4)) else $error("bad status");
endmodule

// ===== test/indexed_min_heap_checker.sv =====
// checker for the indexed min-heap: watches both channels, predicts each result
// from its own heap model and compares field by field; depends on imh_pkg
`timescale 1ns / 1ps
module indexed_min_heap_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_content,
    input  logic [6:0]         i_handle,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic [2:0]         o_status,
    input  logic signed [31:0] o_out_key,
    input  logic [31:0]        o_out_content,
    input  logic [6:0]         o_out_handle,
    input  logic [6:0]         o_entry_count,
    output int                 fail_count,
    output int                 pending_count
);
    import imh_pkg::*;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key;
        logic [31:0]        content;
        logic [6:0]         handle;
        logic [6:0]         count;
    } t_result;

    t_entry   heap_slots [1:CAPACITY];
    int       slot_of [HANDLE_COUNT];
    bit       in_heap [HANDLE_COUNT];
    int       heap_fill;
    t_result  expected_results [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic void swap_slots(int a, int b);
        t_entry t;
        t = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = t;
        slot_of[heap_slots[a].handle] = a;
        slot_of[heap_slots[b].handle] = b;
    endfunction

    function automatic void sift_up(int p, bit forced);
        while (p > 1 && (forced || heap_slots[p].key < heap_slots[p/2].key)) begin
            swap_slots(p, p/2);
            p = p / 2;
        end
    endfunction

    function automatic void sift_down(int p);
        int c;
        while (2*p <= heap_fill) begin
            c = 2*p;
            if (c + 1 <= heap_fill && heap_slots[c+1].key < heap_slots[c].key) c++;
            if (!(heap_slots[c].key < heap_slots[p].key)) break;
            swap_slots(c, p);
            p = c;
        end
    endfunction

    function automatic t_entry pop_root();
        t_entry r;
        r = heap_slots[1];
        in_heap[r.handle] = 0;
        if (heap_fill > 1) begin
            heap_slots[1] = heap_slots[heap_fill];
            slot_of[heap_slots[1].handle] = 1;
        end
        heap_fill--;
        if (heap_fill >= 1) sift_down(1);
        return r;
    endfunction

    function automatic t_result predict_request(logic [1:0] rq, logic signed [31:0] k,
                                                logic [31:0] c, logic [6:0] h);
        t_result r;
        t_entry e;
        r = '0;
        case (t_req'(rq))
            REQ_INSERT: begin
                if (heap_fill >= CAPACITY) r.status = ST_FULL;
                else if (in_heap[h]) r.status = ST_IN_USE;
                else begin
                    heap_fill++;
                    heap_slots[heap_fill] = '{key: k, content: c, handle: h};
                    slot_of[h] = heap_fill;
                    in_heap[h] = 1;
                    sift_up(heap_fill, 0);
                end
            end
            REQ_DEL_MIN: begin
                if (heap_fill == 0) r.status = ST_EMPTY;
                else begin
                    e = pop_root();
                    r.key = e.key;
                    r.content = e.content;
                    r.handle = e.handle;
                end
            end
            REQ_DEL_HANDLE: begin
                if (heap_fill == 0) r.status = ST_EMPTY;
                else if (!in_heap[h]) r.status = ST_UNKNOWN;
                else begin
                    sift_up(slot_of[h], 1);
                    e = pop_root();
                    r.content = e.content;
                    r.handle = e.handle;
                end
            end
            default: ;
        endcase
        r.count = heap_fill[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            heap_fill = 0;
            fail_count = 0;
            foreach (in_heap[i]) in_heap[i] = 0;
            expected_results.delete();
        end else begin
            if (i_valid && !o_stall) begin
                w = predict_request(i_req_type, i_key, i_content, i_handle);
                expected_results = {expected_results, w};
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 32'd1, 32'd0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_status !== w.status) report("status", o_status, w.status);
                    if (o_out_key !== w.key) report("key", o_out_key, w.key);
                    if (o_out_content !== w.content) report("content", o_out_content, w.content);
                    if (o_out_handle !== w.handle) report("handle", o_out_handle, w.handle);
                    if (o_entry_count !== w.count) report("count", o_entry_count, w.count);
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

// ===== test/indexed_min_heap_tb.sv =====
// testbench top for the indexed min-heap: clock, reset, directed and random
// requests with random idling; depends on imh_pkg, indexed_min_heap and indexed_min_heap_checker
`timescale 1ns / 1ps
module indexed_min_heap_tb;
    import imh_pkg::*;

    logic               i_clk, i_rst_n, i_valid, i_stall;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_key;
    logic [31:0]        i_content;
    logic [6:0]         i_handle;
    logic               o_stall, o_valid;
    logic [2:0]         o_status;
    logic signed [31:0] o_out_key;
    logic [31:0]        o_out_content;
    logic [6:0]         o_out_handle, o_entry_count;
    int                 fail_count, pending_count, cycle_count;
    bit                 calm, hold_long;

    indexed_min_heap DUT (.*);
    indexed_min_heap_checker u_checker (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver stalls: random bursts, one long hold, none at the end
    initial begin
        int n;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1;
                repeat (300) @(posedge i_clk);
                i_stall <= 0;
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_stall <= 1;
                repeat (n) @(posedge i_clk);
                i_stall <= 0;
            end
        end
    end

    task automatic send_request(logic [1:0] rq, logic [31:0] k, logic [31:0] c, logic [6:0] h);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= rq;
        i_key <= k;
        i_content <= c;
        i_handle <= h;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0001;
            3: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int r;
        i_rst_n = 0;
        i_valid = 0;
        i_req_type = REQ_NONE;
        i_key = 0;
        i_content = 0;
        i_handle = 0;
        calm = 1;
        hold_long = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(REQ_DEL_MIN, 0, 0, 0);
        send_request(REQ_DEL_HANDLE, 0, 0, 5);
        send_request(REQ_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 7'h7f);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h0, 7'h00);
        send_request(REQ_INSERT, 32'h8000_0001, 32'haaaa_5555, 7'h2a);
        send_request(REQ_INSERT, 0, 32'h5555_aaaa, 7'h55);
        send_request(REQ_INSERT, 0, 1, 7'h55);
        send_request(REQ_DEL_HANDLE, 0, 0, 7'h11);
        send_request(REQ_DEL_HANDLE, 0, 0, 7'h7f);
        send_request(REQ_NONE, 32'hffff_ffff, 32'hffff_ffff, 7'h7f);
        send_request(REQ_DEL_MIN, 0, 0, 0);
        send_request(REQ_DEL_MIN, 0, 0, 0);
        send_request(REQ_DEL_MIN, 0, 0, 0);
        send_request(REQ_DEL_MIN, 0, 0, 0);
        // fill to capacity, then one more to hit full
        for (int i = 0; i < 65; i++)
            send_request(REQ_INSERT, $urandom_range(0, 3), $urandom, 7'(i));
        for (int i = 0; i < 64; i++) send_request(REQ_DEL_MIN, 0, 0, 0);
        calm = 0;
        for (int i = 0; i < 460; i++) begin
            if (i == 100) hold_long = 1;
            if (i == 400) calm = 1;
            r = $urandom_range(0, 9);
            if (r < 5)
                send_request(REQ_INSERT, pick_key(), $urandom, 7'($urandom_range(0, 127)));
            else if (r < 7)
                send_request(REQ_DEL_MIN, $urandom, $urandom, 7'($urandom));
            else if (r < 9)
                send_request(REQ_DEL_HANDLE, $urandom, $urandom, 7'($urandom_range(0, 127)));
            else
                send_request(REQ_NONE, $urandom, $urandom, 7'($urandom));
        end
        i_valid <= 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
